### rtl/pat_pkg.sv
// pat_pkg: shared types and constants of the program association section parser
// holds the parser state struct, the result struct, phase encoding and result codes
// no dependencies
package pat_pkg;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_ENTRY  = 4'b0100,
    PH_CRC    = 4'b1000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_TABLE_ID     = 2'd0;
  localparam logic [1:0] ERR_RESERVED_LEN = 2'd1;
  localparam logic [1:0] ERR_LEN_LARGE    = 2'd2;

  // header byte positions
  localparam logic [2:0] HB_TABLE_ID = 3'd0;
  localparam logic [2:0] HB_LEN_HI   = 3'd1;
  localparam logic [2:0] HB_LEN_LO   = 3'd2;
  localparam logic [2:0] HB_TSID_HI  = 3'd3;
  localparam logic [2:0] HB_TSID_LO  = 3'd4;
  localparam logic [2:0] HB_VERSION  = 3'd5;
  localparam logic [2:0] HB_SECNUM   = 3'd6;

  // last byte of a 4-byte entry or of the crc
  localparam logic [2:0] QUAD_LAST = 3'd3;

  localparam logic [7:0]  TABLE_ID_FORBIDDEN = 8'hFF;
  localparam logic [11:0] LEN_RESERVED_MASK  = 12'hC00;
  localparam logic [11:0] LEN_LIMIT          = 12'h3FD;
  localparam logic [11:0] LEN_FIXED          = 12'd9;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  byte_count;
    logic [11:0] length_field;
    logic [8:0]  entries_left;
    logic [23:0] entry_bytes;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_number;
    logic [7:0]  last_section;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [15:0] program_number;
    logic [12:0] pid;
    logic        is_network;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_number;
    logic [7:0]  last_section_number;
  } result_t;

  // parser state after reset: idle, everything else zero
  localparam state_t STATE_RESET = '{
    phase:          PH_IDLE,
    byte_count:     3'd0,
    length_field:   12'd0,
    entries_left:   9'd0,
    entry_bytes:    24'd0,
    stream_id:      16'd0,
    version:        5'd0,
    current_next:   1'b0,
    section_number: 8'd0,
    last_section:   8'd0
  };

endpackage

### rtl/pat_step.sv
// pat_step: next-state and result logic for one section byte
// combinational; depends on pat_pkg
module pat_step (
  input  pat_pkg::state_t  cur,
  input  logic [7:0]       section_byte,
  input  logic             section_start,
  output pat_pkg::state_t  nxt,
  output logic             res_valid,
  output pat_pkg::result_t res
);

  pat_pkg::phase_t ph;
  logic [2:0]      cnt;
  logic [11:0]     len_full;
  logic [11:0]     len_minus;
  logic [8:0]      entries_new;
  logic [8:0]      entries_dec;

  assign len_full    = {cur.length_field[11:8], section_byte};
  assign len_minus   = cur.length_field - pat_pkg::LEN_FIXED;
  assign entries_new = (cur.length_field >= pat_pkg::LEN_FIXED) ? len_minus[10:2] : 9'd0;
  assign entries_dec = cur.entries_left - 9'd1;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    ph        = section_start ? pat_pkg::PH_HEADER : cur.phase;
    cnt       = section_start ? 3'd0 : cur.byte_count;
    nxt.phase      = ph;
    nxt.byte_count = cnt;

    case (ph)
      pat_pkg::PH_HEADER: begin
        nxt.byte_count = cnt + 3'd1;
        case (cnt)
          pat_pkg::HB_TABLE_ID: begin
            if (section_byte == pat_pkg::TABLE_ID_FORBIDDEN) begin
              res_valid      = 1'b1;
              res.kind       = pat_pkg::KIND_ERROR;
              res.error_code = pat_pkg::ERR_TABLE_ID;
            end
          end
          pat_pkg::HB_LEN_HI: nxt.length_field = {section_byte[3:0], 8'h00};
          pat_pkg::HB_LEN_LO: begin
            nxt.length_field = len_full;
            if ((len_full & pat_pkg::LEN_RESERVED_MASK) != 12'd0) begin
              res_valid      = 1'b1;
              res.kind       = pat_pkg::KIND_ERROR;
              res.error_code = pat_pkg::ERR_RESERVED_LEN;
            end else if (len_full >= pat_pkg::LEN_LIMIT) begin
              res_valid      = 1'b1;
              res.kind       = pat_pkg::KIND_ERROR;
              res.error_code = pat_pkg::ERR_LEN_LARGE;
            end
          end
          pat_pkg::HB_TSID_HI: nxt.stream_id = {section_byte, 8'h00};
          pat_pkg::HB_TSID_LO: nxt.stream_id = {cur.stream_id[15:8], section_byte};
          pat_pkg::HB_VERSION: begin
            nxt.version      = section_byte[5:1];
            nxt.current_next = section_byte[0];
          end
          pat_pkg::HB_SECNUM: nxt.section_number = section_byte;
          default: begin
            nxt.last_section = section_byte;
            nxt.entries_left = entries_new;
            nxt.byte_count   = 3'd0;
            nxt.phase        = (entries_new != 9'd0) ? pat_pkg::PH_ENTRY : pat_pkg::PH_CRC;
          end
        endcase
        // any header error drops back to idle
        if (res_valid) begin
          nxt.phase      = pat_pkg::PH_IDLE;
          nxt.byte_count = 3'd0;
        end
      end

      pat_pkg::PH_ENTRY: begin
        if (cnt < pat_pkg::QUAD_LAST) begin
          nxt.entry_bytes = {cur.entry_bytes[15:0], section_byte};
          nxt.byte_count  = cnt + 3'd1;
        end else begin
          res_valid          = 1'b1;
          res.kind           = pat_pkg::KIND_ENTRY;
          res.program_number = cur.entry_bytes[23:8];
          res.pid            = {cur.entry_bytes[4:0], section_byte};
          res.is_network     = (cur.entry_bytes[23:8] == 16'd0);
          nxt.byte_count     = 3'd0;
          nxt.entries_left   = entries_dec;
          if (entries_dec == 9'd0) begin
            nxt.phase = pat_pkg::PH_CRC;
          end
        end
      end

      pat_pkg::PH_CRC: begin
        if (cnt < pat_pkg::QUAD_LAST) begin
          nxt.byte_count = cnt + 3'd1;
        end else begin
          res_valid               = 1'b1;
          res.kind                = pat_pkg::KIND_DONE;
          res.stream_id           = cur.stream_id;
          res.version             = cur.version;
          res.current_next        = cur.current_next;
          res.section_number      = cur.section_number;
          res.last_section_number = cur.last_section;
          nxt.phase               = pat_pkg::PH_IDLE;
          nxt.byte_count          = 3'd0;
        end
      end

      default: begin
        // idle: bytes are dropped
        nxt.phase      = pat_pkg::PH_IDLE;
        nxt.byte_count = cnt;
      end
    endcase
  end

endmodule

### rtl/pat_section_parser_core.sv
// pat_section_parser_core: byte-serial parser of a program association section
// one byte in per cycle, at most one entry, done or error item out per byte
// depends on pat_pkg and pat_step
//
// a result item is presented on out_* in the cycle after its byte is accepted
// throughput: one byte per cycle; the only hold-off is a full result register not taken
// reset (rst_n low, synchronous): parser idle, all counters and header fields zero,
// result register empty
module pat_section_parser_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_section_byte,
  input  logic        in_section_start,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_program_number,
  output logic [12:0] out_pid,
  output logic        out_is_network,
  output logic [15:0] out_stream_id,
  output logic [4:0]  out_version,
  output logic        out_current_next,
  output logic [7:0]  out_section_number,
  output logic [7:0]  out_last_section_number
);

  // parser state: phase, position counter, length, entry shift register, header fields
  pat_pkg::state_t  state_r;
  pat_pkg::state_t  state_nxt;

  // result register, loaded in the cycle its byte is accepted
  logic             out_valid_r;
  pat_pkg::result_t res_r;

  logic             step_res_valid;
  pat_pkg::result_t step_res;
  logic             in_fire;

  // a byte can enter whenever the result register is empty or being drained this cycle,
  // so the result register doubles as the output stage and no bubble is inserted
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  pat_step u_step (
    .cur           (state_r),
    .section_byte  (in_section_byte),
    .section_start (in_section_start),
    .nxt           (state_nxt),
    .res_valid     (step_res_valid),
    .res           (step_res)
  );

  // state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pat_pkg::STATE_RESET;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result valid: set by a byte that produces an item, cleared when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= step_res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && step_res_valid) begin
      res_r <= step_res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_kind                = res_r.kind;
  assign out_error_code          = res_r.error_code;
  assign out_program_number      = res_r.program_number;
  assign out_pid                 = res_r.pid;
  assign out_is_network          = res_r.is_network;
  assign out_stream_id           = res_r.stream_id;
  assign out_version             = res_r.version;
  assign out_current_next        = res_r.current_next;
  assign out_section_number      = res_r.section_number;
  assign out_last_section_number = res_r.last_section_number;

  // an error item always leaves the parser idle
  a_error_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && step_res_valid && step_res.kind == pat_pkg::KIND_ERROR
      |=> state_r.phase == pat_pkg::PH_IDLE)
    else $error("parser not idle after error item");

  // entry and crc phases only count through one 4-byte group
  a_quad_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == pat_pkg::PH_ENTRY || state_r.phase == pat_pkg::PH_CRC)
      |-> state_r.byte_count <= pat_pkg::QUAD_LAST)
    else $error("byte counter out of range in entry or crc phase");

  // entry phase is never entered or held with nothing left to parse
  a_entries_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == pat_pkg::PH_ENTRY |-> state_r.entries_left != 9'd0)
    else $error("entry phase with zero entries left");

  // network flag only on entry items with program zero
  a_network_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_network
      |-> out_kind == pat_pkg::KIND_ENTRY && out_program_number == 16'd0)
    else $error("network flag on wrong item");

  // phase register stays one-hot
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.phase))
    else $error("phase register not one-hot");

endmodule
